// ----- src/abmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// abmc_pkg
// Types, field offsets, codes and helpers shared by the body mover blocks.
// ----------------------------------------------------------------------------
package abmc_pkg;

  // request kinds, carried in tuser
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_MOVE  = 2'd1;
  localparam logic [1:0] REQ_PLACE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_HB_W   = 3'd0;
  localparam logic [2:0] CFG_HB_H   = 3'd1;
  localparam logic [2:0] CFG_OFF_X  = 3'd2;
  localparam logic [2:0] CFG_OFF_Y  = 3'd3;
  localparam logic [2:0] CFG_COUNT  = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // input tdata layout, lowest bit first
  localparam int unsigned IN_IDX_LSB   = 0;
  localparam int unsigned IN_BOXX_LSB  = 6;
  localparam int unsigned IN_BOXY_LSB  = 22;
  localparam int unsigned IN_BOXW_LSB  = 38;
  localparam int unsigned IN_BOXH_LSB  = 50;
  localparam int unsigned IN_VELX_LSB  = 62;
  localparam int unsigned IN_VELY_LSB  = 78;
  localparam int unsigned IN_DT_LSB    = 94;
  localparam int unsigned IN_PLACX_LSB = 104;
  localparam int unsigned IN_PLACY_LSB = 120;
  localparam int unsigned IN_DATA_W    = 136;

  localparam int unsigned OUT_DATA_W   = 40;

  localparam logic AXIS_Y = 1'b0;
  localparam logic AXIS_X = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [11:0] w;
    logic        [11:0] h;
  } abmc_entry_t;

  typedef struct packed {
    logic load_in;
    logic wr_entry;
    logic place;
    logic mul;
    logic step;
    logic scan_clr;
    logic scan_rd;
    logic snap;
    logic commit;
    logic out_load;
    logic axis;
  } abmc_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic overlap;
    logic out_free;
  } abmc_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) begin
      return 16'sh7fff;
    end else if (v < -22'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/abmc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// abmc_ctrl
// Request sequencer: dispatches writes, places and two-axis move scans; other kinds go straight to the output.
// ----------------------------------------------------------------------------
module abmc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          in_type_i,
  output logic                     in_ready_o,
  input  wire abmc_pkg::abmc_sts_t sts_i,
  output abmc_pkg::abmc_cmd_t      cmd_o
);
  import abmc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WR     = 4'd1;
  localparam logic [3:0] S_PLACE  = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_STEP   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_SNAP   = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       axis_q, axis_d;
  logic       pend_q, pend_d;
  logic       hit;

  assign in_ready_o = (state_q == S_IDLE);
  assign hit        = pend_q && sts_i.overlap;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          unique case (in_type_i)
            REQ_WRITE: state_d = S_WR;
            REQ_MOVE: begin
              state_d = S_MUL;
              axis_d  = AXIS_Y;
            end
            REQ_PLACE: state_d = S_PLACE;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_WR: begin
        cmd_o.wr_entry = 1'b1;
        state_d = S_OUT;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d = S_OUT;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.step     = 1'b1;
        cmd_o.scan_clr = 1'b1;
        pend_d  = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          pend_d  = 1'b0;
          state_d = S_SNAP;
        end else if (sts_i.scan_more) begin
          cmd_o.scan_rd = 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (axis_q == AXIS_Y) begin
              axis_d  = AXIS_X;
              state_d = S_MUL;
            end else begin
              state_d = S_COMMIT;
            end
          end
        end
      end
      S_SNAP: begin
        cmd_o.snap = 1'b1;
        if (axis_q == AXIS_Y) begin
          axis_d  = AXIS_X;
          state_d = S_MUL;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= AXIS_Y;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      pend_q  <= pend_d;
    end
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  a_snap_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.snap |-> $past(hit))
    else $error("snap without a preceding overlap");

  a_no_read_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> !cmd_o.scan_rd)
    else $error("entry read would overwrite the hit entry");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !pend_q && !sts_i.scan_more)
      |=> (state_q == S_MUL || state_q == S_COMMIT))
    else $error("scan did not finish after the last entry");

endmodule
`default_nettype wire

// ----- src/abmc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// abmc_dp
// Datapath: config registers, obstacle memory, step multiplier, overlap
// check, snap and saturation, body position and output register.
// ----------------------------------------------------------------------------
module abmc_dp #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [abmc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [abmc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [abmc_pkg::IN_DATA_W-1:0]      in_data_i,
  input  wire abmc_pkg::abmc_cmd_t                 cmd_i,
  output abmc_pkg::abmc_sts_t                      sts_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [abmc_pkg::OUT_DATA_W-1:0]          out_data_o
);
  import abmc_pkg::*;

  localparam int unsigned ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int unsigned LIM_W  = (CNT_W > 7) ? CNT_W : 7;

  // configuration
  logic        [11:0] hb_w_q, hb_h_q;
  logic signed [11:0] off_x_q, off_y_q;
  logic        [6:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_w_q  <= 12'd16;
      hb_h_q  <= 12'd16;
      off_x_q <= '0;
      off_y_q <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HB_W:  hb_w_q  <= cfg_data_i;
        CFG_HB_H:  hb_h_q  <= cfg_data_i;
        CFG_OFF_X: off_x_q <= $signed(cfg_data_i);
        CFG_OFF_Y: off_y_q <= $signed(cfg_data_i);
        CFG_COUNT: count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic [IN_DATA_W-1:0] in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  logic        [5:0]  in_idx;
  logic signed [15:0] in_vel_x, in_vel_y, in_place_x, in_place_y;
  logic        [9:0]  in_dt;
  abmc_entry_t        in_entry;

  assign in_idx      = in_q[IN_IDX_LSB +: 6];
  assign in_entry.x  = $signed(in_q[IN_BOXX_LSB +: 16]);
  assign in_entry.y  = $signed(in_q[IN_BOXY_LSB +: 16]);
  assign in_entry.w  = in_q[IN_BOXW_LSB +: 12];
  assign in_entry.h  = in_q[IN_BOXH_LSB +: 12];
  assign in_vel_x    = $signed(in_q[IN_VELX_LSB +: 16]);
  assign in_vel_y    = $signed(in_q[IN_VELY_LSB +: 16]);
  assign in_dt       = in_q[IN_DT_LSB +: 10];
  assign in_place_x  = $signed(in_q[IN_PLACX_LSB +: 16]);
  assign in_place_y  = $signed(in_q[IN_PLACY_LSB +: 16]);

  // obstacle memory
  abmc_entry_t        mem [MAX_BOXES];
  abmc_entry_t        rd_q;
  logic [CNT_W-1:0]   scan_idx_q;
  logic [LIM_W-1:0]   limit;
  logic [ADDR_W-1:0]  wr_addr;

  assign wr_addr = ADDR_W'(in_idx);
  assign limit   = (LIM_W'(count_q) > LIM_W'(MAX_BOXES)) ? LIM_W'(MAX_BOXES)
                                                         : LIM_W'(count_q);
  assign sts_o.scan_more = (LIM_W'(scan_idx_q) < limit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry && (32'(in_idx) < MAX_BOXES)) begin
      mem[wr_addr] <= in_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_q <= mem[scan_idx_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_clr) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_idx_q <= scan_idx_q + CNT_W'(1);
    end
  end

  // body state
  logic signed [15:0] body_x_q, body_y_q;
  logic signed [15:0] nx_q, ny_q;
  logic signed [16:0] bx_q, by_q;
  logic signed [26:0] prod_q;
  logic               ground_q;

  logic signed [15:0] vel_sel;
  logic               vel_pos;
  logic signed [26:0] prod_rnd, disp;
  logic signed [15:0] base;
  logic signed [21:0] step_sum;
  logic signed [15:0] step_pos;

  assign vel_sel  = (cmd_i.axis == AXIS_X) ? in_vel_x : in_vel_y;
  assign vel_pos  = !vel_sel[15] && (vel_sel != 16'sd0);
  assign prod_rnd = prod_q + (prod_q[26] ? 27'sd255 : 27'sd0);
  assign disp     = prod_rnd >>> 8;
  assign base     = (cmd_i.axis == AXIS_X) ? body_x_q : body_y_q;
  assign step_sum = 22'(base) + 22'(disp);
  assign step_pos = sat16(step_sum);

  // overlap and snap
  logic signed [19:0] ax, ay, aw, ah, bxs, bys, hw, hh;
  logic signed [19:0] adj;
  logic signed [15:0] snap_base;
  logic signed [21:0] snap_sum;

  assign ax  = 20'(rd_q.x);
  assign ay  = 20'(rd_q.y);
  assign aw  = 20'($signed({1'b0, rd_q.w}));
  assign ah  = 20'($signed({1'b0, rd_q.h}));
  assign bxs = 20'(bx_q);
  assign bys = 20'(by_q);
  assign hw  = 20'($signed({1'b0, hb_w_q}));
  assign hh  = 20'($signed({1'b0, hb_h_q}));

  assign sts_o.overlap = (ax < bxs + hw) && (ax + aw > bxs) &&
                         (ay < bys + hh) && (ay + ah > bys);

  always_comb begin
    if (cmd_i.axis == AXIS_Y) begin
      adj = vel_pos ? (ay - hh - bys) : (ay + ah - bys);
    end else begin
      adj = vel_pos ? (ax - hw - bxs) : (ax + aw - bxs);
    end
  end

  assign snap_base = (cmd_i.axis == AXIS_X) ? nx_q : ny_q;
  assign snap_sum  = 22'(snap_base) + 22'(adj);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 27'(vel_sel) * 27'($signed({1'b0, in_dt}));
    end
    if (cmd_i.step) begin
      if (cmd_i.axis == AXIS_Y) begin
        ny_q <= step_pos;
        by_q <= 17'(step_pos) + 17'(off_y_q);
        bx_q <= 17'(body_x_q) + 17'(off_x_q);
      end else begin
        nx_q <= step_pos;
        bx_q <= 17'(step_pos) + 17'(off_x_q);
        by_q <= 17'(ny_q) + 17'(off_y_q);
      end
    end
    if (cmd_i.snap) begin
      if (cmd_i.axis == AXIS_Y) begin
        ny_q <= sat16(snap_sum);
      end else begin
        nx_q <= sat16(snap_sum);
      end
    end
    if (cmd_i.load_in) begin
      ground_q <= 1'b0;
    end else if (cmd_i.snap && (cmd_i.axis == AXIS_Y) && adj[19]) begin
      ground_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_x_q <= '0;
      body_y_q <= '0;
    end else if (cmd_i.commit) begin
      body_x_q <= nx_q;
      body_y_q <= ny_q;
    end else if (cmd_i.place) begin
      body_x_q <= in_place_x;
      body_y_q <= in_place_y;
    end
  end

  // output register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= {7'd0, body_y_q, body_x_q, ground_q};
    end
  end

endmodule
`default_nettype wire

// ----- src/aabb_move_and_collide.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_move_and_collide
// Body mover with axis-separated box collision resolution against a table
// of obstacle boxes.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tdata: request fields, tuser: kind
//  m_axis   out  tvalid/tready          tdata: on_ground, pos_x, pos_y
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  A write or place request runs one action state, then the output state loads its result.
//  A move checks at most n = min(box_count, MAX_BOXES) entries per axis; each
//  axis scans the obstacle memory one entry per cycle through its single
//  read port, stopping early at the first overlapping entry.
//  Reset is asynchronous active low; the obstacle table is not cleared.
//  A pending result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module aabb_move_and_collide #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // entry_index[5:0], box_x[21:6], box_y[37:22], box_w[49:38], box_h[61:50],
  // vel_x[77:62], vel_y[93:78], delta_t[103:94], place_x[119:104],
  // place_y[135:120]
  input  wire logic [abmc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // req_type[1:0]
  input  wire logic [1:0]                         s_axis_tuser_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // on_ground[0], pos_x[16:1], pos_y[32:17]
  output logic [abmc_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [abmc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [abmc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import abmc_pkg::*;

  abmc_cmd_t cmd;
  abmc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  abmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_type_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abmc_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for aabb_move_and_collide. It drives write, place, move
// and unused-kind requests over the input stream. The bench keeps its own
// model of the body position and the obstacle table, and predicts one result
// per request. Each result is compared field by field in order. A short
// directed set covers saturation, landing, wall and ceiling snaps and
// zero-velocity moves. It is followed by a table fill and eight register
// setups of random, mostly local traffic; all but the last add random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  import abmc_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam logic [1:0]  REQ_NONE    = 2'd3;
  localparam int          PHASE_ITEMS = 55;
  localparam int          SETTLE_WAIT = 300;
  // ~530 items, each with up to two full table scans plus gaps and stalls
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct {
    logic               ground;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } body_pos_t;

  class body_tracker;
    abmc_entry_t        obstacles [TABLE_DEPTH];
    logic signed [15:0] body_x, body_y;
    logic [11:0]        hb_w, hb_h;
    logic signed [11:0] off_x, off_y;
    logic [6:0]         box_count;
    body_pos_t          expected_pos [$];
    int errors, requests, results, moves, landings, snaps;

    function new();
      body_x = '0;
      body_y = '0;
      hb_w = 12'd16;
      hb_h = 12'd16;
      off_x = '0;
      off_y = '0;
      box_count = '0;
      errors = 0;
      requests = 0;
      results = 0;
      moves = 0;
      landings = 0;
      snaps = 0;
    endfunction

    function int pending();
      return expected_pos.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HB_W:  hb_w = val;
        CFG_HB_H:  hb_h = val;
        CFG_OFF_X: off_x = val;
        CFG_OFF_Y: off_y = val;
        CFG_COUNT: box_count = val[6:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // push-out for the first overlapping entry, 0 if none
    function longint snap_amount(longint bx, longint by, bit vertical, bit positive);
      longint ax, ay, aw, ah, w, h;
      int n;
      w = hb_w;
      h = hb_h;
      n = (box_count > TABLE_DEPTH) ? TABLE_DEPTH : box_count;
      for (int i = 0; i < n; i++) begin
        ax = longint'($signed(obstacles[i].x));
        ay = longint'($signed(obstacles[i].y));
        aw = longint'(obstacles[i].w);
        ah = longint'(obstacles[i].h);
        if (ax < bx + w && ax + aw > bx && ay < by + h && ay + ah > by) begin
          if (vertical) return positive ? ay - h - by : ay + ah - by;
          return positive ? ax - w - bx : ax + aw - bx;
        end
      end
      return 0;
    endfunction

    function void note_request(logic [1:0] kind, logic [IN_DATA_W-1:0] data);
      body_pos_t          r;
      logic [5:0]         idx;
      logic signed [15:0] vx, vy;
      logic [9:0]         dt;
      longint             nx, ny, adj;
      r.ground = 1'b0;
      case (kind)
        REQ_WRITE: begin
          idx = data[IN_IDX_LSB +: 6];
          obstacles[idx].x = data[IN_BOXX_LSB +: 16];
          obstacles[idx].y = data[IN_BOXY_LSB +: 16];
          obstacles[idx].w = data[IN_BOXW_LSB +: 12];
          obstacles[idx].h = data[IN_BOXH_LSB +: 12];
        end
        REQ_MOVE: begin
          vx = data[IN_VELX_LSB +: 16];
          vy = data[IN_VELY_LSB +: 16];
          dt = data[IN_DT_LSB +: 10];
          ny = clamp16(longint'(body_y) + (longint'(vy) * longint'(dt)) / 256);
          adj = snap_amount(longint'(body_x) + off_x, ny + off_y, 1'b1, vy > 0);
          if (adj < 0) r.ground = 1'b1;
          if (adj != 0) snaps++;
          ny = clamp16(ny + adj);
          nx = clamp16(longint'(body_x) + (longint'(vx) * longint'(dt)) / 256);
          adj = snap_amount(nx + off_x, ny + off_y, 1'b0, vx > 0);
          if (adj != 0) snaps++;
          nx = clamp16(nx + adj);
          body_x = nx[15:0];
          body_y = ny[15:0];
          moves++;
          if (r.ground) landings++;
        end
        REQ_PLACE: begin
          body_x = data[IN_PLACX_LSB +: 16];
          body_y = data[IN_PLACY_LSB +: 16];
        end
        default: ;
      endcase
      r.x = body_x;
      r.y = body_y;
      expected_pos.push_back(r);
      requests++;
    endfunction

    task report(string msg);
      // count all, print a bounded number
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] tdata);
      body_pos_t want;
      if (expected_pos.size() == 0) begin
        report($sformatf("result %h with no request outstanding", tdata));
        return;
      end
      want = expected_pos.pop_front();
      if (tdata[0] !== want.ground)
        report($sformatf("result %0d on_ground %b, want %b", results, tdata[0], want.ground));
      if (tdata[16:1] !== want.x)
        report($sformatf("result %0d pos_x %0d, want %0d", results,
                         $signed(tdata[16:1]), want.x));
      if (tdata[32:17] !== want.y)
        report($sformatf("result %0d pos_y %0d, want %0d", results,
                         $signed(tdata[32:17]), want.y));
      results++;
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [1:0]            s_axis_tuser_i = REQ_WRITE;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_HB_W;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  body_tracker sb;
  bit          idling = 1'b1;
  int          stall_left = 0;
  int          setups = 0;
  int          cycle_count = 0;

  aabb_move_and_collide dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // result side: check each accepted item, stall in bursts while idling is set
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("FAIL aabb_move_and_collide");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] noise_bits();
    logic [159:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return v[IN_DATA_W-1:0];
  endfunction

  function automatic logic signed [15:0] rnd_near();
    int v;
    v = int'($urandom_range(0, 600)) - 300;
    return v[15:0];
  endfunction

  function automatic logic [11:0] rnd_size();
    if ($urandom_range(0, 19) == 0) return 12'd0;
    return 12'($urandom_range(1, 80));
  endfunction

  function automatic logic signed [15:0] rnd_vel();
    int v;
    v = int'($urandom_range(0, 8192)) - 4096;
    return v[15:0];
  endfunction

  task automatic send_item(logic [1:0] kind, logic [IN_DATA_W-1:0] d);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tdata_i <= d;
    s_axis_tuser_i <= kind;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(kind, d);
  endtask

  task automatic send_write(logic [5:0] idx, logic signed [15:0] x, logic signed [15:0] y,
                            logic [11:0] w, logic [11:0] h);
    logic [IN_DATA_W-1:0] d;
    d = noise_bits();
    d[IN_IDX_LSB +: 6] = idx;
    d[IN_BOXX_LSB +: 16] = x;
    d[IN_BOXY_LSB +: 16] = y;
    d[IN_BOXW_LSB +: 12] = w;
    d[IN_BOXH_LSB +: 12] = h;
    send_item(REQ_WRITE, d);
  endtask

  task automatic send_move(logic signed [15:0] vx, logic signed [15:0] vy, logic [9:0] dt);
    logic [IN_DATA_W-1:0] d;
    d = noise_bits();
    d[IN_VELX_LSB +: 16] = vx;
    d[IN_VELY_LSB +: 16] = vy;
    d[IN_DT_LSB +: 10] = dt;
    send_item(REQ_MOVE, d);
  endtask

  task automatic send_place(logic signed [15:0] x, logic signed [15:0] y);
    logic [IN_DATA_W-1:0] d;
    d = noise_bits();
    d[IN_PLACX_LSB +: 16] = x;
    d[IN_PLACY_LSB +: 16] = y;
    send_item(REQ_PLACE, d);
  endtask

  task automatic stop_items();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic apply_setup(logic [11:0] w, logic [11:0] h, logic [11:0] ox,
                             logic [11:0] oy, logic [11:0] n);
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs = '{CFG_HB_W, CFG_HB_H, CFG_OFF_X, CFG_OFF_Y, CFG_COUNT};
    vals = '{w, h, ox, oy, n};
    for (int i = 0; i < 5; i++) begin
      cfg_index_i <= regs[i];
      cfg_data_i <= vals[i];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
    setups++;
  endtask

  task automatic random_item(bit wild);
    int pick;
    pick = $urandom_range(0, 99);
    if (wild) send_item(2'($urandom_range(0, 3)), noise_bits());
    else if (pick < 20) send_write(6'($urandom_range(0, TABLE_DEPTH - 1)), rnd_near(),
                                   rnd_near(), rnd_size(), rnd_size());
    else if (pick < 75) send_move(rnd_vel(), rnd_vel(), 10'($urandom_range(0, 16)));
    else if (pick < 95) send_place(rnd_near(), rnd_near());
    else send_item(REQ_NONE, noise_bits());
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setup, empty scan: saturation, zero time, unused kind
    send_item(REQ_NONE, '1);
    send_place(16'sh7fff, 16'sh8000);
    send_move(16'sh7fff, 16'sh8000, 10'd1023);
    send_place(16'sh8000, 16'sh7fff);
    send_move(16'sh8000, 16'sh7fff, 10'd1023);
    send_move(16'sd256, -16'sd256, 10'd0);
    send_item(REQ_WRITE, '0);
    send_write(6'd0, 16'sh8000, 16'sh8000, 12'd4095, 12'd4095);
    send_write(6'd1, 16'sh7fff, 16'sh7fff, 12'd0, 12'd0);
    send_write(6'd2, -16'sd100, 16'sd40, 12'd300, 12'd20);
    send_write(6'd3, 16'sd60, -16'sd200, 12'd20, 12'd240);
    send_write(6'd4, 16'sd32000, 16'sd32000, 12'd4095, 12'd4095);
    send_write(6'd63, -16'sd5, 16'sd7, 12'd1, 12'd1);
    stop_items();
    settle();
    apply_setup(12'd16, 12'd16, 12'd0, 12'd0, 12'd5);

    // landing, walls from both sides, zero velocity, ceiling, clamp after snap
    send_place(16'sd0, 16'sd0);
    send_move(16'sd0, 16'sd2560, 10'd5);
    send_move(16'sd2560, 16'sd0, 10'd6);
    send_place(16'sd90, 16'sd0);
    send_move(-16'sd2560, 16'sd0, 10'd2);
    send_place(16'sd0, 16'sd45);
    send_move(16'sd0, 16'sd0, 10'd3);
    send_place(16'sd0, 16'sd80);
    send_move(16'sd0, -16'sd2560, 10'd3);
    send_place(16'sd32100, 16'sd32100);
    send_move(-16'sd256, -16'sd256, 10'd1);
    send_place(-16'sd30000, -16'sd30000);
    send_move(-16'sd256, -16'sd256, 10'd1);

    // populate every entry so any count is safe to scan
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_write(6'(i), rnd_near(), rnd_near(), rnd_size(), rnd_size());
    stop_items();
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setup(12'd16, 12'd16, 12'd0, 12'd0, 12'd64);
        1: apply_setup(12'd0, 12'd0, 12'h800, 12'h7ff, 12'd127);
        2: apply_setup(12'd4095, 12'd4095, 12'h7ff, 12'h800, 12'd100);
        3, 4: apply_setup(12'($urandom_range(1, 64)), 12'($urandom_range(1, 64)),
                          12'(int'($urandom_range(0, 64)) - 32),
                          12'(int'($urandom_range(0, 64)) - 32),
                          12'($urandom_range(0, 64)));
        5: apply_setup(12'd8, 12'd24, -12'sd4, -12'sd8, 12'd64);
        6: apply_setup(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 127)));
        default: begin
          idling = 1'b0;
          apply_setup(12'd16, 12'd16, 12'd0, 12'd0, 12'd16);
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          stop_items();
          settle();
        end
        random_item($urandom_range(0, 99) < 15);
      end
      stop_items();
      settle();
    end

    repeat (SETTLE_WAIT) @(posedge clk_i);
    $display("ran %0d requests: %0d moves, %0d landings, %0d axis snaps",
             sb.requests, sb.moves, sb.landings, sb.snaps);
    $display("%0d register setups incl. zero/max hitbox, extreme offsets, counts 0..127",
             setups);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS aabb_move_and_collide");
    end else begin
      $display("FAIL aabb_move_and_collide");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/abmc_pkg.sv
src/abmc_ctrl.sv
src/abmc_dp.sv
src/aabb_move_and_collide.sv
bench/tb.sv
